@@ sv/dotted_quad_ipv4_parser_unit_assert.svh @@
// assertion macros for the dotted-quad ipv4 parser unit
`ifndef DOTTED_QUAD_IPV4_PARSER_UNIT_ASSERT_SVH
`define DOTTED_QUAD_IPV4_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DQP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define DQP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/dqp_pkg.sv @@
// types and constants shared by the dotted-quad parser modules
package dqp_pkg;

   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [8:0] ACCUM_LIMIT = 9'd256;
   localparam logic [1:0] OCTET_LAST  = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0] address;
      status_type  status;
   } result_type;

   // what the parser step yields for the character in the input stage
   typedef struct packed {
      logic       emit;
      result_type result;
   } step_type;

endpackage

@@ sv/dqp_req_if.sv @@
// character input channel
interface dqp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

@@ sv/dqp_rsp_if.sv @@
// parsed address result channel
interface dqp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   logic [1:0]  status;

   modport source (output valid, output address, output status, input ready);
   modport sink   (input valid, input address, input status, output ready);
endinterface

@@ sv/dqp_in_reg.sv @@
// input register for one character beat
module dqp_in_reg (
   input  logic       clock,
   input  logic       reset,
   dqp_req_if.sink    req_chan,
   input  logic       take,
   output logic       valid,
   output logic [7:0] ch
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] ch_ff;
   logic       load;

   // room when empty or when the held beat leaves this cycle
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         ch_ff <= req_chan.ch;
      end
   end

   assign valid = valid_ff;
   assign ch    = ch_ff;
endmodule

@@ sv/dqp_parser.sv @@
// parser state and the per-character next-state logic
module dqp_parser
   import dqp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] ch,
   input  logic       take,
   output step_type   step
);
   logic [1:0]  octet_index_ff, octet_index_in;
   logic [8:0]  octet_accum_ff, octet_accum_in;
   logic [23:0] partial_ff, partial_in;

   logic        is_digit;
   logic [7:0]  ch_off;
   logic [3:0]  digit;
   logic [11:0] scaled;
   logic        over_range;

   // digit decode and accumulate, times ten as two shifts
   assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign ch_off     = ch - CH_ZERO;
   assign digit      = ch_off[3:0];
   assign scaled     = {octet_accum_ff, 3'b000} + {2'b00, octet_accum_ff, 1'b0}
                       + {8'd0, digit};
   assign over_range = (octet_accum_ff >= ACCUM_LIMIT);

   always_comb begin
      step.emit           = 1'b0;
      step.result.address = '0;
      step.result.status  = STATUS_OK;
      octet_index_in      = octet_index_ff;
      octet_accum_in      = octet_accum_ff;
      partial_in          = partial_ff;
      if (is_digit) begin
         // saturate at the limit
         octet_accum_in = (scaled >= {3'b000, ACCUM_LIMIT}) ? ACCUM_LIMIT : scaled[8:0];
      end else if (octet_index_ff != OCTET_LAST) begin
         if (ch != CH_DOT) begin
            step.emit          = 1'b1;
            step.result.status = STATUS_BAD_CHAR;
         end else if (over_range) begin
            step.emit          = 1'b1;
            step.result.status = STATUS_RANGE;
         end else begin
            partial_in     = {partial_ff[15:0], octet_accum_ff[7:0]};
            octet_accum_in = '0;
            octet_index_in = octet_index_ff + 2'd1;
         end
      end else begin
         // fourth octet ends on any non-digit
         step.emit = 1'b1;
         if (over_range) begin
            step.result.status = STATUS_RANGE;
         end else begin
            step.result.address = {partial_ff, octet_accum_ff[7:0]};
         end
      end
      // any result restarts the parse
      if (step.emit) begin
         octet_index_in = '0;
         octet_accum_in = '0;
         partial_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octet_index_ff <= '0;
         octet_accum_ff <= '0;
         partial_ff     <= '0;
      end else if (take) begin
         octet_index_ff <= octet_index_in;
         octet_accum_ff <= octet_accum_in;
         partial_ff     <= partial_in;
      end
   end
endmodule

@@ sv/dqp_out_reg.sv @@
// result register on the output channel
module dqp_out_reg
   import dqp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       free,
   dqp_rsp_if.source  rsp_chan
);
   logic        valid_ff, valid_in;
   result_type  result_ff;

   // slot usable when empty or draining now
   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.address = result_ff.address;
   assign rsp_chan.status  = result_ff.status;
endmodule

@@ sv/dotted_quad_ipv4_parser_unit.sv @@
// top level of the dotted-quad ipv4 address parser
//
//   channel    dir   payload                       beat when
//   req_chan   in    ch[7:0]                       valid && ready
//   rsp_chan   out   address[31:0], status[1:0]    valid && ready
//
// one character per cycle while no result is held up; a character waits in the input
// register, is parsed against the octet state, and any result lands in the output
// register in the cycle after the character is parsed
// reset clears the octet state and both valid flags
// a held result stalls only a character that would itself produce a result;
// digits, and dots that close one of the first three octets in range, keep flowing behind it
`include "dotted_quad_ipv4_parser_unit_assert.svh"

module dotted_quad_ipv4_parser_unit
   import dqp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dqp_req_if.sink   req_chan,
   dqp_rsp_if.source rsp_chan
);
   logic       s1_valid;
   logic [7:0] s1_ch;
   logic       take;
   logic       out_free;
   step_type   step;

   dqp_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .valid    (s1_valid),
      .ch       (s1_ch)
   );

   dqp_parser u_parser (
      .clock (clock),
      .reset (reset),
      .ch    (s1_ch),
      .take  (take),
      .step  (step)
   );

   // parse the held character unless its result has nowhere to go
   assign take = s1_valid && (!step.emit || out_free);

   dqp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (take && step.emit),
      .result   (step.result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   `DQP_ASSERT_SAME(a_error_zero_addr, clock, reset,
      rsp_chan.valid && (rsp_chan.status != STATUS_OK), rsp_chan.address == 32'd0,
      "error result carries a nonzero address")
   `DQP_ASSERT_NEXT(a_result_lands, clock, reset, take && step.emit,
      rsp_chan.valid, "parsed result did not reach the output register")
   `DQP_ASSERT_NEXT(a_held_char_kept, clock, reset, s1_valid && !take,
      s1_valid && (s1_ch == $past(s1_ch)), "stalled character lost from input stage")
   `DQP_ASSERT_SAME(a_status_code, clock, reset, rsp_chan.valid,
      (rsp_chan.status == STATUS_OK) || (rsp_chan.status == STATUS_BAD_CHAR) ||
      (rsp_chan.status == STATUS_RANGE), "undefined status code on output")
endmodule
